// ===== rtl/slcg_pkg.sv =====
// ----------------------------------------------------------------------------
// slcg_pkg: shared types, constants and helpers of the shuffled LCG core
// Holds the generator constants, the power-up shuffle table contents and the
// controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package slcg_pkg;

    localparam int unsigned SEED_W  = 32;
    localparam int unsigned WORD_W  = 31;
    localparam int unsigned TBL_DEPTH = 128;
    localparam int unsigned TBL_AW  = $clog2(TBL_DEPTH);
    localparam int unsigned OUT_W   = 64;

    localparam logic [31:0] LCG_MUL = 32'h7fffffed;
    localparam logic [31:0] LCG_ADD = 32'h7fffffc3;
    localparam logic [31:0] LCG_MOD = 32'h7fffffff;

    // Power-up contents of the shuffle table
    localparam logic [WORD_W-1:0] INIT_TABLE [TBL_DEPTH] = '{
        31'h4c8bc0aa, 31'h4c022957, 31'h2232827a, 31'h2f1e7626,
        31'h7f8bdafb, 31'h5c37d02a, 31'h0ab48f72, 31'h2f0c4ffa,
        31'h290e1954, 31'h6b635f23, 31'h5d3885c0, 31'h74b49ff8,
        31'h5155fa54, 31'h6214ad3f, 31'h111e9c29, 31'h242a3a09,
        31'h75932ae1, 31'h40ac432e, 31'h54f7ba7a, 31'h585ccbd5,
        31'h6df5c727, 31'h0374dad1, 31'h7112b3f1, 31'h735fc311,
        31'h404331a9, 31'h74d97781, 31'h64495118, 31'h323e04be,
        31'h5974b425, 31'h4862e393, 31'h62389c1d, 31'h28a68b82,
        31'h0f95da37, 31'h7a50bbc6, 31'h09b0091c, 31'h22cdb7b4,
        31'h4faaed26, 31'h66417ccd, 31'h189e4bfa, 31'h1ce4e8dd,
        31'h5274c742, 31'h3bdcf4dc, 31'h2d94e907, 31'h32eac016,
        31'h26d33ca3, 31'h60415a8a, 31'h31f57880, 31'h68c8aa52,
        31'h23eb16da, 31'h6204f4a1, 31'h373927c1, 31'h0d24eb7c,
        31'h06dd7379, 31'h2b3be507, 31'h0f9c55b1, 31'h2c7925eb,
        31'h36d67c9a, 31'h42f831d9, 31'h5e3961cb, 31'h65d637a8,
        31'h24bb3820, 31'h4d08e33d, 31'h2188754f, 31'h147e409e,
        31'h6a9620a0, 31'h62e26657, 31'h7bd8ce81, 31'h11da0abb,
        31'h5f9e7b50, 31'h23e444b6, 31'h25920c78, 31'h5fc894f0,
        31'h5e338cbb, 31'h404237fd, 31'h1d60f80f, 31'h320a1743,
        31'h76013d2b, 31'h070294ee, 31'h695e243b, 31'h56b177fd,
        31'h752492e1, 31'h6decd52f, 31'h125f5219, 31'h139d2e78,
        31'h1898d11e, 31'h2f7ee785, 31'h4db405d8, 31'h1a028a35,
        31'h63f6f323, 31'h1f6d0078, 31'h307cfd67, 31'h3f32a78a,
        31'h6980796c, 31'h462b3d83, 31'h34b639f2, 31'h53fce379,
        31'h74ba50f4, 31'h1abc2c4b, 31'h5eeaeb8d, 31'h335a7a0d,
        31'h3973dd20, 31'h0462d66b, 31'h159813ff, 31'h1e4643fd,
        31'h06bc5c62, 31'h3115e3fc, 31'h09101613, 31'h47af2515,
        31'h4f11ec54, 31'h78b99911, 31'h3db8dd44, 31'h1ec10b9b,
        31'h5b5506ca, 31'h773ce092, 31'h567be81a, 31'h5475b975,
        31'h7a2cde1a, 31'h494536f5, 31'h34737bb4, 31'h76d9750b,
        31'h2a1f6232, 31'h2e49644d, 31'h7dddcbe7, 31'h500cebdb,
        31'h619dab9e, 31'h48c626fe, 31'h1cda3193, 31'h52dabe9d
    };

    // Controller to datapath commands
    typedef struct packed {
        logic mul_seed;   // multiply the incoming seed
        logic cap_x;      // reduce product into x
        logic mul_x;      // multiply x
        logic cap_seed;   // reduce product into the new seed
        logic rd_en;      // read the selected table entry
        logic commit;     // load result, write x back
    } slcg_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;   // output register can take a result
    } slcg_stat_t;

    // Multiply-add, wrapped to 32 bits
    function automatic logic [SEED_W-1:0] lcg_mac(input logic [SEED_W-1:0] v);
        logic [SEED_W-1:0] p;
        begin
            p = v * LCG_MUL + LCG_ADD;
            return p;
        end
    endfunction

    // Reduce a 32-bit value modulo 2^31-1: fold the top bit, subtract once
    function automatic logic [WORD_W-1:0] lcg_reduce(input logic [SEED_W-1:0] t);
        logic [SEED_W-1:0] r;
        logic [SEED_W-1:0] d;
        begin
            r = {1'b0, t[WORD_W-1:0]} + {{(SEED_W-1){1'b0}}, t[SEED_W-1]};
            d = r - LCG_MOD;
            if (r >= LCG_MOD)
            begin
                return d[WORD_W-1:0];
            end
            return r[WORD_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/shuffled_lcg_random_core.sv =====
// ----------------------------------------------------------------------------
// shuffled_lcg_random_core: LCG generator with a 128-word shuffle table
// m_tvalid rises on a commit, which waits for a free output register. No
// new request is taken until the last one commits; the single multiply-add
// unit runs twice per request and the table port does one read and one
// write. Reset: control clears at once; the table reads its power-up words
// through per-entry valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module shuffled_lcg_random_core
    import slcg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [SEED_W-1:0] s_tdata,   // [31:0] seed_in
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata    // [31:0] random_value, [62:32] seed_out, [63] zero
);

    slcg_cmd_t         cmd;
    slcg_stat_t        stat;
    logic [SEED_W-1:0] random_value;
    logic [WORD_W-1:0] seed_out;

    slcg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    slcg_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .seed_in      (s_tdata),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .random_value (random_value),
        .seed_out     (seed_out)
    );

    assign m_tdata = {1'b0, seed_out, random_value};

    // One request in flight: ready drops after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in flight");

    // A result appears only through a commit
    a_rise_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.commit))
        else $error("result appeared without a commit");

    // Seed stays below the modulus
    a_seed_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[62:32] != 31'h7fffffff)
        else $error("seed_out not reduced");

    // Table words never reach bit 31
    a_rand_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[31] && !m_tdata[63])
        else $error("random_value out of range");

endmodule

// ===== rtl/slcg_ram.sv =====
// ----------------------------------------------------------------------------
// slcg_ram: generic single-port RAM
// One read or write port, registered read data.
// ----------------------------------------------------------------------------
module slcg_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/slcg_ctrl.sv =====
// ----------------------------------------------------------------------------
// slcg_ctrl: sequencing state machine
// Steps one request through two multiply/reduce rounds, the table read and
// the result commit.
// ----------------------------------------------------------------------------
module slcg_ctrl
    import slcg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  slcg_stat_t stat,
    output slcg_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED1,
        ST_MUL2,
        ST_RED2,
        ST_READ,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RED1;
                end
            end
            ST_RED1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_RED2;
            ST_RED2:   state_next = ST_READ;
            ST_READ:   state_next = ST_COMMIT;
            ST_COMMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode commands
    assign in_ready     = (state_reg == ST_IDLE);
    assign cmd.mul_seed = (state_reg == ST_IDLE) && in_valid;
    assign cmd.cap_x    = (state_reg == ST_RED1);
    assign cmd.mul_x    = (state_reg == ST_MUL2);
    assign cmd.cap_seed = (state_reg == ST_RED2);
    assign cmd.rd_en    = (state_reg == ST_READ);
    assign cmd.commit   = (state_reg == ST_COMMIT) && stat.out_free;

endmodule

// ===== rtl/slcg_dp.sv =====
// ----------------------------------------------------------------------------
// slcg_dp: generator datapath
// Shared multiply-add unit, modulo reduction, shuffle table with per-entry
// valid bits and the output register.
// ----------------------------------------------------------------------------
module slcg_dp
    import slcg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  slcg_cmd_t         cmd,
    output slcg_stat_t        stat,
    input  logic [SEED_W-1:0] seed_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SEED_W-1:0] random_value,
    output logic [WORD_W-1:0] seed_out
);

    logic [SEED_W-1:0]    prod_reg;
    logic [WORD_W-1:0]    x_reg;
    logic [WORD_W-1:0]    seed_reg;
    logic [TBL_DEPTH-1:0] valid_reg;
    logic                 out_valid_reg;
    logic [WORD_W-1:0]    rand_reg;
    logic [WORD_W-1:0]    seed_out_reg;
    logic [SEED_W-1:0]    mac_in;
    logic [TBL_AW-1:0]    pos;
    logic [WORD_W-1:0]    ram_rdata;
    logic [WORD_W-1:0]    old_word;

    assign pos    = seed_reg[TBL_AW-1:0];
    assign mac_in = cmd.mul_seed ? seed_in : {1'b0, x_reg};

    // Entries never rewritten still read as their power-up word
    assign old_word = valid_reg[pos] ? ram_rdata : INIT_TABLE[pos];

    // Multiply and reduce registers
    always_ff @(posedge clk)
    begin
        if (cmd.mul_seed || cmd.mul_x)
        begin
            prod_reg <= lcg_mac(mac_in);
        end
        if (cmd.cap_x)
        begin
            x_reg <= lcg_reduce(prod_reg);
        end
        if (cmd.cap_seed)
        begin
            seed_reg <= lcg_reduce(prod_reg);
        end
        if (cmd.commit)
        begin
            rand_reg     <= old_word;
            seed_out_reg <= seed_reg;
        end
    end

    // Track rewritten entries and output occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                valid_reg[pos] <= 1'b1;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    slcg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (cmd.commit),
        .re    (cmd.rd_en),
        .addr  (pos),
        .wdata (x_reg),
        .rdata (ram_rdata)
    );

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign random_value  = {1'b0, rand_reg};
    assign seed_out      = seed_out_reg;

endmodule

// ===== tb/shuffled_lcg_random_core_tb.sv =====
// ----------------------------------------------------------------------------
// shuffled_lcg_random_core_tb: self-checking bench for the shuffled LCG core
// Drives seed requests over the input stream and keeps its own copy of the
// 128-word shuffle table, which is loaded from the power-up words. Each seed
// is run through the two generator steps to predict the drawn word and the
// new seed. Every output request is compared against the oldest prediction.
// Both stream sides throttle at random. Coverage includes edge seeds,
// chained draws, same-slot back-to-back hits and random seeds.
// ----------------------------------------------------------------------------
module shuffled_lcg_random_core_tb;

    import slcg_pkg::*;

    localparam int unsigned CLK_HALF   = 10;
    localparam int unsigned RUN_LIMIT  = 5_000_000;
    localparam int unsigned SETTLE_CYC = 12;

    localparam logic [31:0] GEN_MUL = 32'h7fffffed;
    localparam logic [31:0] GEN_ADD = 32'h7fffffc3;
    localparam logic [31:0] GEN_MOD = 32'h7fffffff;

    // Power-up shuffle table contents
    localparam logic [31:0] POWER_UP_WORDS [128] = '{
        32'h4c8bc0aa, 32'h4c022957, 32'h2232827a, 32'h2f1e7626,
        32'h7f8bdafb, 32'h5c37d02a, 32'h0ab48f72, 32'h2f0c4ffa,
        32'h290e1954, 32'h6b635f23, 32'h5d3885c0, 32'h74b49ff8,
        32'h5155fa54, 32'h6214ad3f, 32'h111e9c29, 32'h242a3a09,
        32'h75932ae1, 32'h40ac432e, 32'h54f7ba7a, 32'h585ccbd5,
        32'h6df5c727, 32'h0374dad1, 32'h7112b3f1, 32'h735fc311,
        32'h404331a9, 32'h74d97781, 32'h64495118, 32'h323e04be,
        32'h5974b425, 32'h4862e393, 32'h62389c1d, 32'h28a68b82,
        32'h0f95da37, 32'h7a50bbc6, 32'h09b0091c, 32'h22cdb7b4,
        32'h4faaed26, 32'h66417ccd, 32'h189e4bfa, 32'h1ce4e8dd,
        32'h5274c742, 32'h3bdcf4dc, 32'h2d94e907, 32'h32eac016,
        32'h26d33ca3, 32'h60415a8a, 32'h31f57880, 32'h68c8aa52,
        32'h23eb16da, 32'h6204f4a1, 32'h373927c1, 32'h0d24eb7c,
        32'h06dd7379, 32'h2b3be507, 32'h0f9c55b1, 32'h2c7925eb,
        32'h36d67c9a, 32'h42f831d9, 32'h5e3961cb, 32'h65d637a8,
        32'h24bb3820, 32'h4d08e33d, 32'h2188754f, 32'h147e409e,
        32'h6a9620a0, 32'h62e26657, 32'h7bd8ce81, 32'h11da0abb,
        32'h5f9e7b50, 32'h23e444b6, 32'h25920c78, 32'h5fc894f0,
        32'h5e338cbb, 32'h404237fd, 32'h1d60f80f, 32'h320a1743,
        32'h76013d2b, 32'h070294ee, 32'h695e243b, 32'h56b177fd,
        32'h752492e1, 32'h6decd52f, 32'h125f5219, 32'h139d2e78,
        32'h1898d11e, 32'h2f7ee785, 32'h4db405d8, 32'h1a028a35,
        32'h63f6f323, 32'h1f6d0078, 32'h307cfd67, 32'h3f32a78a,
        32'h6980796c, 32'h462b3d83, 32'h34b639f2, 32'h53fce379,
        32'h74ba50f4, 32'h1abc2c4b, 32'h5eeaeb8d, 32'h335a7a0d,
        32'h3973dd20, 32'h0462d66b, 32'h159813ff, 32'h1e4643fd,
        32'h06bc5c62, 32'h3115e3fc, 32'h09101613, 32'h47af2515,
        32'h4f11ec54, 32'h78b99911, 32'h3db8dd44, 32'h1ec10b9b,
        32'h5b5506ca, 32'h773ce092, 32'h567be81a, 32'h5475b975,
        32'h7a2cde1a, 32'h494536f5, 32'h34737bb4, 32'h76d9750b,
        32'h2a1f6232, 32'h2e49644d, 32'h7dddcbe7, 32'h500cebdb,
        32'h619dab9e, 32'h48c626fe, 32'h1cda3193, 32'h52dabe9d
    };

    typedef struct packed {
        logic [31:0] random_value;
        logic [30:0] seed_out;
    } draw_t;

    logic              clk;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [SEED_W-1:0] s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    // Predictor state and expected draws
    logic [31:0] slot_words [128];
    logic [31:0] last_seed_out;
    logic [6:0]  last_slot;
    draw_t       pending_draws [$];

    bit          throttle_on;
    int          err_count;
    int          seeds_sent;
    int          draws_checked;
    int          same_slot_pairs;
    int          ready_hold = 0;

    shuffled_lcg_random_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // One generator step: wrap the multiply-add, then reduce mod 2^31-1
    function automatic logic [31:0] gen_step(input logic [31:0] v);
        logic [31:0] t;
        begin
            t = v * GEN_MUL + GEN_ADD;
            return t % GEN_MOD;
        end
    endfunction

    // Seed whose wrapped multiply-add lands exactly on the given value
    function automatic logic [31:0] seed_for_sum(input logic [31:0] target);
        logic [31:0] inv;
        begin
            inv = GEN_MUL;
            repeat (5) inv = inv * (32'd2 - GEN_MUL * inv);
            return (target - GEN_ADD) * inv;
        end
    endfunction

    // Mostly short gaps, a few long ones, none when throttling is off
    function automatic int pick_gap();
        int r;
        begin
            if (!throttle_on)
            begin
                return 0;
            end
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                return 0;
            end
            if (r < 90)
            begin
                return $urandom_range(1, 3);
            end
            return $urandom_range(8, 30);
        end
    endfunction

    // Predict one draw and update the table copy
    task automatic predict_draw(input logic [31:0] seed);
        logic [31:0] x;
        logic [31:0] nxt;
        logic [6:0]  slot;
        draw_t       d;
        begin
            x    = gen_step(seed);
            nxt  = gen_step(x);
            slot = nxt[6:0];
            d.random_value = slot_words[slot];
            d.seed_out     = nxt[30:0];
            pending_draws.push_back(d);
            slot_words[slot] = x;
            if (seeds_sent != 0 && slot == last_slot)
            begin
                same_slot_pairs++;
            end
            last_slot     = slot;
            last_seed_out = nxt;
            seeds_sent++;
        end
    endtask

    // Send one seed request; valid stays high into the next request unless a gap comes
    task automatic send_seed(input logic [31:0] seed);
        int gap;
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                s_tdata  <= $urandom();
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= seed;
            @(posedge clk);
            while (!s_tready) @(posedge clk);
            predict_draw(seed);
        end
    endtask

    // Drop valid and wait until every predicted draw has come back
    task automatic wait_drain();
        begin
            s_tvalid <= 1'b0;
            while (pending_draws.size() != 0) @(posedge clk);
            repeat (SETTLE_CYC) @(posedge clk);
        end
    endtask

    task automatic test_directed_edges();
        logic [31:0] seeds [$];
        begin
            throttle_on = 1'b0;
            seeds = '{32'h0000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                      32'h7fff_fffe, 32'h0000_0001, 32'haaaa_aaaa, 32'h5555_5555,
                      seed_for_sum(32'h7fff_ffff), seed_for_sum(32'hffff_fffe),
                      seed_for_sum(32'hffff_ffff), seed_for_sum(32'h7fff_fffe),
                      seed_for_sum(32'h0000_0000), seed_for_sum(32'h8000_0000)};
            foreach (seeds[i]) send_seed(seeds[i]);
            // repeat one seed back to back: same slot read right after its write
            repeat (3) send_seed(32'h1234_5678);
            repeat (3) send_seed(seed_for_sum(32'h7fff_ffff));
            wait_drain();
        end
    endtask

    // Feed each new seed back in, as a caller would
    task automatic test_chained_draws();
        begin
            throttle_on = 1'b1;
            send_seed($urandom());
            for (int i = 0; i < 300; i++)
            begin
                if (i % 60 == 30)
                begin
                    throttle_on = ~throttle_on;
                end
                if ($urandom_range(0, 19) == 0)
                begin
                    send_seed($urandom());
                end
                else
                begin
                    send_seed(last_seed_out);
                end
            end
            wait_drain();
        end
    endtask

    // Pairs of one seed hit the same slot twice in a row
    task automatic test_same_slot_repeats();
        logic [31:0] seed;
        begin
            for (int i = 0; i < 30; i++)
            begin
                throttle_on = (i % 2 == 0);
                seed = $urandom();
                send_seed(seed);
                send_seed(seed);
            end
            wait_drain();
        end
    endtask

    task automatic test_random_seeds();
        begin
            for (int i = 0; i < 300; i++)
            begin
                if (i % 50 == 0)
                begin
                    throttle_on = ($urandom_range(0, 3) != 0);
                end
                send_seed($urandom());
            end
            wait_drain();
        end
    endtask

    // Stall the output side at random
    always @(posedge clk)
    begin : sink_ctl
        int g;
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
            m_tready   <= 1'b0;
        end
        else
        begin
            g = pick_gap();
            if (g > 0)
            begin
                ready_hold <= g - 1;
                m_tready   <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Check each output request against the oldest prediction
    always @(posedge clk)
    begin : draw_check
        draw_t d;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_draws.size() == 0)
            begin
                $display("%0t: unexpected draw, actual %h", $time, m_tdata);
                err_count++;
            end
            else
            begin
                d = pending_draws.pop_front();
                draws_checked++;
                if (m_tdata[31:0] !== d.random_value)
                begin
                    $display("%0t: random_value expected %h actual %h",
                             $time, d.random_value, m_tdata[31:0]);
                    err_count++;
                end
                if (m_tdata[62:32] !== d.seed_out)
                begin
                    $display("%0t: seed_out expected %h actual %h",
                             $time, d.seed_out, m_tdata[62:32]);
                    err_count++;
                end
                if (m_tdata[63] !== 1'b0)
                begin
                    $display("%0t: pad bit expected 0 actual %b", $time, m_tdata[63]);
                    err_count++;
                end
            end
        end
    end

    // Hold reset, then run the tests in turn
    initial
    begin
        err_count       = 0;
        seeds_sent      = 0;
        draws_checked   = 0;
        same_slot_pairs = 0;
        throttle_on     = 1'b0;
        last_slot       = '0;
        last_seed_out   = '0;
        foreach (slot_words[i]) slot_words[i] = POWER_UP_WORDS[i];
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_chained_draws();
        test_same_slot_repeats();
        test_random_seeds();

        if (pending_draws.size() != 0)
        begin
            $display("%0t: %0d draws never arrived", $time, pending_draws.size());
            err_count++;
        end
        $display("Sent %0d seeds (edge, chained, same-slot, random), checked %0d draws,",
                 seeds_sent, draws_checked);
        $display("with %0d same-slot back-to-back hits and random stalls on both sides.",
                 same_slot_pairs);
        if (err_count == 0)
        begin
            $display("PASS shuffled_lcg_random_core");
        end
        else
        begin
            $display("FAIL shuffled_lcg_random_core");
        end
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #(RUN_LIMIT);
        $display("%0t: run timed out", $time);
        $display("FAIL shuffled_lcg_random_core");
        $finish;
    end

endmodule
